/* rtl/mds_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mds_pkg: shared types and constants of the duplicate suppressor
// Table geometry, field widths, register map and the result beat layout.
// ---------------------------------------------------------------------------
package mds_pkg;

   // table geometry
   localparam int SLOTS        = 32;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int ADDR_W       = 48;
   localparam int TIME_W       = 32;
   localparam int ENTRY_W      = ADDR_W + TIME_W;
   localparam int SLOT_FIELD_W = 5;
   localparam int IDX_EXT_W    = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

   // register map
   localparam int                  CSR_ADDR_W     = 2;
   localparam int                  CSR_DATA_W     = 32;
   localparam logic [CSR_ADDR_W-1:0] ADDR_COOLDOWN = 2'd0;
   localparam logic [TIME_W-1:0]   COOLDOWN_RESET = 32'd30000;

   // beat widths
   localparam int REQ_DATA_W = ADDR_W + TIME_W;
   localparam int RSP_DATA_W = 8;

   // result of one lookup
   typedef struct packed {
      logic                    suppressed;
      logic                    inserted;
      logic [SLOT_FIELD_W-1:0] slot_used;
   } res_type;

   // low bits of a slot index as reported on the result beat
   function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] idx);
      logic [IDX_EXT_W-1:0] ext;
      ext = IDX_EXT_W'(idx);
      return ext[SLOT_FIELD_W-1:0];
   endfunction

endpackage

/* rtl/mds_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mds_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module mds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mds_csr.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mds_csr: configuration register block
// APB-style access to the cooldown window register.
// ---------------------------------------------------------------------------
module mds_csr import mds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [TIME_W-1:0]     cooldown
);

   logic [TIME_W-1:0] cooldown_ff;
   logic [TIME_W-1:0] cooldown_in;
   logic              wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr == ADDR_COOLDOWN);

   // register write
   always_comb begin
      cooldown_in = cooldown_ff;
      if (wr_hit) begin
         cooldown_in = csr_pwdata[TIME_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooldown_ff <= COOLDOWN_RESET;
      end else begin
         cooldown_ff <= cooldown_in;
      end
   end

   // read decode
   always_comb begin
      unique case (csr_paddr)
         ADDR_COOLDOWN: csr_prdata = CSR_DATA_W'(cooldown_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cooldown = cooldown_ff;

endmodule

/* rtl/mds_scan.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mds_scan: table search and update engine
// Sweeps the entry RAM one slot a cycle, stops at the first address match,
// then decides suppress, refresh or insert and writes the entry back.
// ---------------------------------------------------------------------------
module mds_scan import mds_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ADDR_W-1:0] start_addr,
   input  logic [TIME_W-1:0] start_now,
   input  logic [TIME_W-1:0] cooldown,
   input  logic              out_free,
   output logic              idle,
   output logic              done,
   output res_type           result
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [SLOT_W-1:0] iss_ff, iss_in;
   logic              iss_done_ff, iss_done_in;
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              vld_rd_ff, vld_rd_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [SLOT_W-1:0] ptr_ff, ptr_in;
   logic [SLOTS-1:0]  valid_ff, valid_in;

   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ADDR_W-1:0]  ent_addr;
   logic [TIME_W-1:0]  ent_time;
   logic [TIME_W-1:0]  age;
   logic               supp;

   // entry store: time in the high bits, address in the low bits
   mds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (iss_ff),
      .rd_data (rd_data)
   );

   // a never-written slot reads as the all-zero entry
   assign ent_addr = vld_rd_ff ? rd_data[ADDR_W-1:0] : '0;
   assign ent_time = vld_rd_ff ? rd_data[ENTRY_W-1:ADDR_W] : '0;

   // wrapping age of the matched entry and cooldown check
   assign age     = now_ff - time_ff;
   assign supp    = hit_ff & (age < cooldown);
   assign wr_data = {now_ff, addr_ff};

   assign rd_en = (state_ff == ST_SCAN) & ~iss_done_ff;
   assign idle  = (state_ff == ST_IDLE);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      addr_in     = addr_ff;
      now_in      = now_ff;
      iss_in      = iss_ff;
      iss_done_in = iss_done_ff;
      pend_in     = rd_en;
      cmp_idx_in  = iss_ff;
      vld_rd_in   = valid_ff[iss_ff];
      hit_in      = hit_ff;
      slot_in     = slot_ff;
      time_in     = time_ff;
      ptr_in      = ptr_ff;
      valid_in    = valid_ff;
      wr_en       = 1'b0;
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               addr_in     = start_addr;
               now_in      = start_now;
               iss_in      = '0;
               iss_done_in = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue the next slot read
            if (rd_en) begin
               iss_in      = iss_ff + SLOT_W'(1);
               iss_done_in = (iss_ff == LAST_SLOT);
            end
            // compare the slot whose read was issued in the previous cycle
            if (pend_ff) begin
               if (ent_addr == addr_ff) begin
                  hit_in   = 1'b1;
                  slot_in  = cmp_idx_ff;
                  time_in  = ent_time;
                  state_in = ST_DECIDE;
               end else if (cmp_idx_ff == LAST_SLOT) begin
                  hit_in   = 1'b0;
                  slot_in  = ptr_ff;
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            // write back once the result register can take the beat
            if (out_free) begin
               wr_en = ~supp;
               // only a slot that is actually written becomes valid
               if (~supp) begin
                  valid_in[slot_ff] = 1'b1;
               end
               if (~hit_ff) begin
                  ptr_in = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + SLOT_W'(1);
               end
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.suppressed = supp;
   assign result.inserted   = ~hit_ff;
   assign result.slot_used  = slot_field(slot_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         ptr_ff   <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         ptr_ff   <= ptr_in;
         valid_ff <= valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      now_ff      <= now_in;
      iss_ff      <= iss_in;
      iss_done_ff <= iss_done_in;
      cmp_idx_ff  <= cmp_idx_in;
      vld_rd_ff   <= vld_rd_in;
      hit_ff      <= hit_in;
      slot_ff     <= slot_in;
      time_ff     <= time_in;
   end

endmodule

/* rtl/mac_duplicate_suppressor.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mac_duplicate_suppressor: repeat-address filter with cooldown window
// Each request beat carries a 48-bit device address and a millisecond time.
// The block looks the address up in a 32-slot table held in one RAM and
// answers with one response beat: suppressed when the address was seen less
// than cooldown_ms ago, inserted when it was new and took the round-robin
// slot, and the slot index in either case. One request is handled at a
// time: the RAM is read one slot per cycle in slot order, so a hit returns
// sooner the lower its slot and a miss only after the last slot is compared,
// plus any wait for the response side. The table reads as all zeros after
// reset, so the all-zero address first matches slot 0.
// ---------------------------------------------------------------------------
module mac_duplicate_suppressor import mds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request beat
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [47:0] device_address, [79:48] now_ms
   // response beat
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] suppressed, [1] inserted,
                                              // [6:2] slot_used, [7] zero
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [TIME_W-1:0] cooldown;
   logic              scan_idle;
   logic              scan_done;
   res_type           scan_res;
   logic              out_free;
   logic              req_beat;

   logic              rsp_valid_ff, rsp_valid_in;
   res_type           rsp_res_ff, rsp_res_in;

   // configuration registers
   mds_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cooldown    (cooldown)
   );

   assign req_tready = scan_idle;
   assign req_beat   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // table search engine
   mds_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (req_beat),
      .start_addr (req_tdata[ADDR_W-1:0]),
      .start_now  (req_tdata[REQ_DATA_W-1:ADDR_W]),
      .cooldown   (cooldown),
      .out_free   (out_free),
      .idle       (scan_idle),
      .done       (scan_done),
      .result     (scan_res)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (rsp_valid_ff & rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (scan_done) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = scan_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff.slot_used, rsp_res_ff.inserted,
                        rsp_res_ff.suppressed};

`ifndef SYNTH
   // one lookup in flight: no new request right after one is taken
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> ~req_tready)
      else $error("request accepted while a lookup is in progress");

   // a finished lookup never overwrites a pending response
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      scan_done |-> out_free)
      else $error("response register overwritten");

   // a response is never both suppressed and inserted
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ~(rsp_res_ff.suppressed & rsp_res_ff.inserted))
      else $error("suppressed and inserted both set");

   // a cooldown write takes effect on the next cycle
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel & csr_penable & csr_pwrite & (csr_paddr == ADDR_COOLDOWN))
      |=> (cooldown == $past(csr_pwdata[TIME_W-1:0])))
      else $error("cooldown register not updated");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench of the mac_duplicate_suppressor
// Drives request beats of address and time, and predicts each response
// (suppressed, inserted, slot) from its own copy of the slot table. Directed
// beats cover the zero-address start, the time wrap and the cooldown
// extremes. Random beats revisit a pool of addresses so that hits, refreshes,
// suppressions and round-robin evictions all happen. Both sides stall.
// ---------------------------------------------------------------------------
module tb;
   import mds_pkg::*;

   localparam int POOL_SIZE   = 48;
   localparam int PHASE_BEATS = 190;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 40;

   // table model and store of expected responses
   class suppress_scoreboard;
      logic [ADDR_W-1:0] slot_addr [SLOTS];
      logic [TIME_W-1:0] slot_stamp [SLOTS];
      int unsigned       next_slot;
      logic [TIME_W-1:0] cooldown;
      res_type           pending [$];
      int                mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_addr[i]  = '0;
            slot_stamp[i] = '0;
         end
         next_slot  = 0;
         cooldown   = COOLDOWN_RESET;
         mismatches = 0;
      endfunction

      function void set_cooldown(input logic [TIME_W-1:0] value);
         cooldown = value;
      endfunction

      // lowest matching slot wins, a miss takes the round-robin slot
      function void note_request(input logic [REQ_DATA_W-1:0] beat);
         logic [ADDR_W-1:0] addr;
         logic [TIME_W-1:0] now;
         logic [TIME_W-1:0] age;
         res_type           want;
         bit                hit;
         addr = beat[ADDR_W-1:0];
         now  = beat[ADDR_W +: TIME_W];
         hit  = 1'b0;
         want = '0;
         for (int i = 0; i < SLOTS && !hit; i++) begin
            if (slot_addr[i] == addr) begin
               hit = 1'b1;
               age = now - slot_stamp[i];
               if (age < cooldown) begin
                  want.suppressed = 1'b1;
               end else begin
                  slot_stamp[i] = now;
               end
               want.slot_used = SLOT_FIELD_W'(i);
            end
         end
         if (!hit) begin
            slot_addr[next_slot]  = addr;
            slot_stamp[next_slot] = now;
            want.inserted  = 1'b1;
            want.slot_used = SLOT_FIELD_W'(next_slot);
            next_slot = (next_slot + 1) % SLOTS;
         end
         pending.push_back(want);
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(input logic [RSP_DATA_W-1:0] beat);
         res_type want;
         if (pending.size() == 0) begin
            report($sformatf("response %h with no request waiting", beat));
         end else begin
            want = pending.pop_front();
            if (beat[0] !== want.suppressed)
               report($sformatf("suppressed %b, expected %b", beat[0], want.suppressed));
            if (beat[1] !== want.inserted)
               report($sformatf("inserted %b, expected %b", beat[1], want.inserted));
            if (beat[6:2] !== want.slot_used)
               report($sformatf("slot_used %0d, expected %0d", beat[6:2], want.slot_used));
            if (beat[7] !== 1'b0)
               report("pad bit of response beat is not zero");
         end
      endtask
   endclass

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // [47:0] device_address, [79:48] now_ms
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // [0] suppressed, [1] inserted,
                                              // [6:2] slot_used, [7] zero
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   suppress_scoreboard sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_len      = 0;
   int quiet         = 0;

   mac_duplicate_suppressor dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // beat monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      end
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_len != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_len) @(posedge clock);
            hold_len = 0;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one request beat, then maybe a gap
   task automatic send_lookup(input logic [ADDR_W-1:0] addr, input logic [TIME_W-1:0] now);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {now, addr};
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and let every response come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // setup and access cycle of a register write
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_COOLDOWN) sb.set_cooldown(data);
   endtask

   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [ADDR_W-1:0] ALT_A    = 48'hAAAA_AAAA_AAAA;
   localparam logic [ADDR_W-1:0] ALT_5    = 48'h5555_5555_5555;

   initial begin
      logic [TIME_W-1:0] cool;
      logic [TIME_W-1:0] clock_ms;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] last_addr;
      int unsigned       span;
      int                r;

      addr_pool[0] = '0;
      addr_pool[1] = ALL_ONES;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'({$urandom, $urandom});

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero address at start, cooldown boundary, time wrap
      send_lookup('0, 32'd0);
      send_lookup('0, 32'd30000);
      send_lookup('0, 32'd59999);
      send_lookup(ALL_ONES, 32'hFFFF_FFFF);
      send_lookup('0, 32'd5);
      send_lookup(ALL_ONES, 32'd4);
      send_lookup(ALL_ONES, 32'hFFFF_FFF0);
      send_lookup(ALT_A, 32'h5555_5555);
      send_lookup(ALT_5, 32'hAAAA_AAAA);

      // zero cooldown: every hit passes
      drain();
      write_csr(ADDR_COOLDOWN, 32'd0);
      send_lookup(ALL_ONES, 32'hFFFF_FFF0);
      send_lookup('0, 32'd0);

      // widest cooldown: only an age of all ones passes
      drain();
      write_csr(ADDR_COOLDOWN, 32'hFFFF_FFFF);
      send_lookup(ALL_ONES, 32'hFFFF_FFEF);
      send_lookup(ALL_ONES, 32'd0);
      send_lookup(ALT_A, 32'd0);

      // random phases over stall patterns and cooldown settings
      clock_ms  = $urandom;
      last_addr = addr_pool[2];
      for (int phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 8;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (phase)
            0: cool = 32'd1000;
            1: cool = 32'd0;
            2: cool = $urandom_range(1, 20000);
            3: cool = 32'hFFFF_FFFF;
            4: cool = COOLDOWN_RESET;
            default: cool = $urandom;
         endcase
         drain();
         write_csr(ADDR_COOLDOWN, cool);
         // time steps sized so that pool revisits land near the cooldown
         span = (cool >= 48) ? cool / 24 : 50;

         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (phase == 0 && n == 40) hold_len = HOLD_CYCLES;
            r = $urandom_range(99);
            if (r < 15) addr = last_addr;
            else if (r < 80) addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            else addr = ADDR_W'({$urandom, $urandom});
            if ($urandom_range(99) < 4) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, span);
            send_lookup(addr, clock_ms);
            last_addr = addr;
         end
      end

      // wind down and give the verdict
      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending.size()));
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
